[sv/ilist_pkg.sv]
// ----------------------------------------------------------------------------
// Indexed list package
// Sizes, codes and the command/status bundles shared by the list engine's
// controller, its datapath and the top level.
// ----------------------------------------------------------------------------
package ilist_pkg;

   // list storage
   localparam int CAPACITY    = 128;
   localparam int ADDR_W      = $clog2(CAPACITY);
   localparam int CNT_W       = $clog2(CAPACITY + 1);

   // beat field widths
   localparam int POS_W       = 8;
   localparam int VALUE_W     = 32;
   localparam int FOUND_W     = 7;
   localparam int COUNT_OUT_W = 8;

   // width for comparing a position with the count
   localparam int CMP_W       = (POS_W > CNT_W) ? POS_W : CNT_W;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_SEARCH = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_BADPOS  = 2'd2,
      ST_MISSING = 2'd3
   } status_type;

   // memory read address source
   typedef enum logic [1:0] {
      RD_BELOW = 2'd0,
      RD_ABOVE = 2'd1,
      RD_AT    = 2'd2
   } rd_sel_type;

   // index counter start value
   typedef enum logic [1:0] {
      IDX_COUNT = 2'd0,
      IDX_POS   = 2'd1,
      IDX_ZERO  = 2'd2
   } idx_sel_type;

   typedef struct packed {
      logic        load_req;
      logic        idx_load;
      idx_sel_type idx_sel;
      logic        idx_inc;
      logic        idx_dec;
      rd_sel_type  rd_sel;
      logic        shift_wr;
      logic        final_wr;
      logic        cnt_inc;
      logic        cnt_dec;
      logic        res_set;
      status_type  res_status;
      logic        res_found;
      logic        rsp_load;
   } cmd_type;

   typedef struct packed {
      op_type           op;
      logic             full;
      logic             pos_gt_count;
      logic             pos_ge_count;
      logic             idx_eq_pos;
      logic             idx_last;
      logic             idx_end;
      logic             match;
      logic             rsp_free;
      logic [CNT_W-1:0] count;
   } sts_type;

endpackage

[sv/ilist_datapath.sv]
// ----------------------------------------------------------------------------
// Indexed list datapath
// Entry memory with one write and one registered read port, entry count,
// walking index, captured command and the result register.
// ----------------------------------------------------------------------------
module ilist_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ilist_pkg::cmd_type                   cmd,
   output ilist_pkg::sts_type                   sts,
   input  logic [1:0]                           req_opcode,
   input  logic [ilist_pkg::POS_W-1:0]          req_position,
   input  logic signed [ilist_pkg::VALUE_W-1:0] req_value,
   input  logic                                 rsp_stall,
   output logic                                 rsp_valid,
   output logic [1:0]                           rsp_status,
   output logic [ilist_pkg::FOUND_W-1:0]        rsp_found_position,
   output logic [ilist_pkg::COUNT_OUT_W-1:0]    rsp_entry_count
);

   // captured command beat
   ilist_pkg::op_type                    op_ff;
   logic [ilist_pkg::POS_W-1:0]          pos_ff;
   logic signed [ilist_pkg::VALUE_W-1:0] val_ff;

   // walking index and count
   logic [ilist_pkg::CNT_W-1:0]          idx_ff, idx_in;
   logic [ilist_pkg::CNT_W-1:0]          count_ff, count_in;

   // entry memory
   logic signed [ilist_pkg::VALUE_W-1:0] mem [ilist_pkg::CAPACITY];
   logic signed [ilist_pkg::VALUE_W-1:0] rd_data_ff;
   logic [ilist_pkg::ADDR_W-1:0]         rd_addr;

   // pending result and output register
   ilist_pkg::status_type                res_status_ff;
   logic [ilist_pkg::FOUND_W-1:0]        res_found_ff;
   logic                                 rsp_valid_ff, rsp_valid_in;
   ilist_pkg::status_type                rsp_status_ff;
   logic [ilist_pkg::FOUND_W-1:0]        rsp_found_ff;
   logic [ilist_pkg::COUNT_OUT_W-1:0]    rsp_count_ff;

   logic [ilist_pkg::CMP_W-1:0]          pos_x, cnt_x, idx_x;

   // capture the command beat
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff  <= ilist_pkg::op_type'(req_opcode);
         pos_ff <= req_position;
         val_ff <= req_value;
      end
   end

   // index counter
   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_load) begin
         case (cmd.idx_sel)
            ilist_pkg::IDX_COUNT: idx_in = count_ff;
            ilist_pkg::IDX_POS:   idx_in = ilist_pkg::CNT_W'(pos_ff);
            default:              idx_in = '0;
         endcase
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + ilist_pkg::CNT_W'(1);
      end else if (cmd.idx_dec) begin
         idx_in = idx_ff - ilist_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
   end

   // entry count
   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + ilist_pkg::CNT_W'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - ilist_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // read address: neighbour below, neighbour above or the index itself
   always_comb begin
      case (cmd.rd_sel)
         ilist_pkg::RD_BELOW: rd_addr = ilist_pkg::ADDR_W'(idx_ff - ilist_pkg::CNT_W'(1));
         ilist_pkg::RD_ABOVE: rd_addr = ilist_pkg::ADDR_W'(idx_ff + ilist_pkg::CNT_W'(1));
         default:             rd_addr = ilist_pkg::ADDR_W'(idx_ff);
      endcase
   end

   // memory: shifted word to the index, or the new value to its position
   always_ff @(posedge clock) begin
      if (cmd.shift_wr) begin
         mem[ilist_pkg::ADDR_W'(idx_ff)] <= rd_data_ff;
      end else if (cmd.final_wr) begin
         mem[ilist_pkg::ADDR_W'(pos_ff)] <= val_ff;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // pending result
   always_ff @(posedge clock) begin
      if (cmd.res_set) begin
         res_status_ff <= cmd.res_status;
         res_found_ff  <= cmd.res_found ? ilist_pkg::FOUND_W'(idx_ff) : '0;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_found_ff  <= res_found_ff;
         rsp_count_ff  <= ilist_pkg::COUNT_OUT_W'(count_ff);
      end
   end

   // status towards the controller
   assign pos_x = ilist_pkg::CMP_W'(pos_ff);
   assign cnt_x = ilist_pkg::CMP_W'(count_ff);
   assign idx_x = ilist_pkg::CMP_W'(idx_ff);

   always_comb begin
      sts.op           = op_ff;
      sts.full         = count_ff >= ilist_pkg::CNT_W'(ilist_pkg::CAPACITY);
      sts.pos_gt_count = pos_x > cnt_x;
      sts.pos_ge_count = pos_x >= cnt_x;
      sts.idx_eq_pos   = idx_x == pos_x;
      sts.idx_last     = ({1'b0, idx_ff} + {{ilist_pkg::CNT_W{1'b0}}, 1'b1})
                         >= {1'b0, count_ff};
      sts.idx_end      = idx_ff >= count_ff;
      sts.match        = rd_data_ff == val_ff;
      sts.rsp_free     = !rsp_valid_ff || !rsp_stall;
      sts.count        = count_ff;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_found_position = rsp_found_ff;
   assign rsp_entry_count    = rsp_count_ff;

endmodule

[sv/ilist_ctrl.sv]
// ----------------------------------------------------------------------------
// Indexed list controller
// Sequences one command at a time: checks, shift walk or search walk,
// then hands the result to the output register.
// ----------------------------------------------------------------------------
module ilist_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  ilist_pkg::sts_type sts,
   output ilist_pkg::cmd_type cmd
);

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_DECIDE = 9'b000000010,
      S_UP_RD  = 9'b000000100,
      S_UP_WR  = 9'b000001000,
      S_DN_RD  = 9'b000010000,
      S_DN_WR  = 9'b000100000,
      S_SR_RD  = 9'b001000000,
      S_SR_CMP = 9'b010000000,
      S_FINISH = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECIDE;
            end
         end
         S_DECIDE: begin
            unique case (sts.op)
               ilist_pkg::OP_INSERT: begin
                  if (sts.full) begin
                     cmd.res_set    = 1'b1;
                     cmd.res_status = ilist_pkg::ST_FULL;
                     state_in       = S_FINISH;
                  end else if (sts.pos_gt_count) begin
                     cmd.res_set    = 1'b1;
                     cmd.res_status = ilist_pkg::ST_BADPOS;
                     state_in       = S_FINISH;
                  end else begin
                     cmd.idx_load = 1'b1;
                     cmd.idx_sel  = ilist_pkg::IDX_COUNT;
                     state_in     = S_UP_RD;
                  end
               end
               ilist_pkg::OP_DELETE: begin
                  if (sts.pos_ge_count) begin
                     cmd.res_set    = 1'b1;
                     cmd.res_status = ilist_pkg::ST_BADPOS;
                     state_in       = S_FINISH;
                  end else begin
                     cmd.idx_load = 1'b1;
                     cmd.idx_sel  = ilist_pkg::IDX_POS;
                     state_in     = S_DN_RD;
                  end
               end
               ilist_pkg::OP_SEARCH: begin
                  cmd.idx_load = 1'b1;
                  cmd.idx_sel  = ilist_pkg::IDX_ZERO;
                  state_in     = S_SR_RD;
               end
               default: begin
                  // unused opcode: no change, plain ok
                  cmd.res_set    = 1'b1;
                  cmd.res_status = ilist_pkg::ST_OK;
                  state_in       = S_FINISH;
               end
            endcase
         end
         // insert: move entries up from the top down to the position
         S_UP_RD: begin
            if (sts.idx_eq_pos) begin
               cmd.final_wr   = 1'b1;
               cmd.cnt_inc    = 1'b1;
               cmd.res_set    = 1'b1;
               cmd.res_status = ilist_pkg::ST_OK;
               state_in       = S_FINISH;
            end else begin
               cmd.rd_sel = ilist_pkg::RD_BELOW;
               state_in   = S_UP_WR;
            end
         end
         S_UP_WR: begin
            cmd.shift_wr = 1'b1;
            cmd.idx_dec  = 1'b1;
            state_in     = S_UP_RD;
         end
         // delete: move entries down from the position to the top
         S_DN_RD: begin
            if (sts.idx_last) begin
               cmd.cnt_dec    = 1'b1;
               cmd.res_set    = 1'b1;
               cmd.res_status = ilist_pkg::ST_OK;
               state_in       = S_FINISH;
            end else begin
               cmd.rd_sel = ilist_pkg::RD_ABOVE;
               state_in   = S_DN_WR;
            end
         end
         S_DN_WR: begin
            cmd.shift_wr = 1'b1;
            cmd.idx_inc  = 1'b1;
            state_in     = S_DN_RD;
         end
         // search: read, then compare, lowest position first
         S_SR_RD: begin
            if (sts.idx_end) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = ilist_pkg::ST_MISSING;
               state_in       = S_FINISH;
            end else begin
               cmd.rd_sel = ilist_pkg::RD_AT;
               state_in   = S_SR_CMP;
            end
         end
         S_SR_CMP: begin
            if (sts.match) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = ilist_pkg::ST_OK;
               cmd.res_found  = 1'b1;
               state_in       = S_FINISH;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_SR_RD;
            end
         end
         S_FINISH: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = reset || (state_ff != S_IDLE);

endmodule

[sv/indexed_list_insert_delete_search_core.sv]
// ----------------------------------------------------------------------------
// Indexed list insert / delete / search core
// Each shifted or searched entry takes a registered read, then the write or the
// compare. One command at a time; the next is taken in the cycle after the result
// is loaded, also while that result still waits.
// Reset clears the count and the controller; the entry memory is not cleared.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete_search_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_opcode,
   input  logic [ilist_pkg::POS_W-1:0]          req_position,
   input  logic signed [ilist_pkg::VALUE_W-1:0] req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [1:0]                           rsp_status,
   output logic [ilist_pkg::FOUND_W-1:0]        rsp_found_position,
   output logic [ilist_pkg::COUNT_OUT_W-1:0]    rsp_entry_count
);

   ilist_pkg::cmd_type cmd;
   ilist_pkg::sts_type sts;

   // sequencer
   ilist_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // storage and result path
   ilist_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_opcode         (req_opcode),
      .req_position       (req_position),
      .req_value          (req_value),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_found_position (rsp_found_position),
      .rsp_entry_count    (rsp_entry_count)
   );

   // count never passes capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      sts.count <= ilist_pkg::CNT_W'(ilist_pkg::CAPACITY))
      else $error("entry count above capacity");

   // growth only from a list with room
   a_inc_room: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_inc |-> !sts.full)
      else $error("insert completed on a full list");

   // a full report goes with a full list
   a_full_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ilist_pkg::ST_FULL) |->
      rsp_entry_count == ilist_pkg::COUNT_OUT_W'(ilist_pkg::CAPACITY))
      else $error("full status with list not full");

   // a miss reports position zero
   a_miss_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ilist_pkg::ST_MISSING) |-> rsp_found_position == '0)
      else $error("search miss with non-zero position");

   // no result loaded over one still waiting
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !(rsp_valid && rsp_stall))
      else $error("result overwritten while stalled");

endmodule

[verif/indexed_list_insert_delete_search_core_tb.sv]
// ----------------------------------------------------------------------------
// Indexed list core testbench
// Drives insert, delete and search commands into the list engine under random
// idling on both channels. A shadow copy of the list works out each expected
// response beat, and every accepted response is compared with it field by
// field. The run covers an empty list, a full list, bad positions, duplicates,
// search hits and misses, and the unused opcode.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete_search_core_tb;

   // unused opcode: the core answers with ok and the current count
   localparam logic [1:0] OP_UNUSED     = 2'd3;
   localparam int         HOLD_CYCLES   = 300;
   localparam int         DRAIN_CYCLES  = 300;
   localparam int         WATCHDOG_LIMIT = 4000;

   typedef enum {LEAN_EVEN, LEAN_FILL, LEAN_DRAIN} lean_type;

   typedef struct {
      ilist_pkg::status_type                status;
      logic [ilist_pkg::FOUND_W-1:0]        found;
      logic [ilist_pkg::COUNT_OUT_W-1:0]    held_after;
   } outcome_type;

   // shadow list and the queue of response beats still owed by the core
   class list_shadow;
      logic signed [ilist_pkg::VALUE_W-1:0] cells[ilist_pkg::CAPACITY];
      int                                   held;
      outcome_type                          outcomes_due[$];
      int                                   errors;

      function new();
         held   = 0;
         errors = 0;
      endfunction

      function int pending();
         return outcomes_due.size();
      endfunction

      // apply one accepted command to the shadow list, queue its response
      function void take_command(logic [1:0] op, logic [ilist_pkg::POS_W-1:0] pos,
                                 logic signed [ilist_pkg::VALUE_W-1:0] val);
         outcome_type o;
         int          k;
         bit          hit;
         o.status = ilist_pkg::ST_OK;
         o.found  = '0;
         hit      = 1'b0;
         case (op)
            ilist_pkg::OP_INSERT: begin
               if (held >= ilist_pkg::CAPACITY) begin
                  o.status = ilist_pkg::ST_FULL;
               end else if (pos > held) begin
                  o.status = ilist_pkg::ST_BADPOS;
               end else begin
                  for (k = held; k > pos; k--) cells[k] = cells[k-1];
                  cells[pos] = val;
                  held++;
               end
            end
            ilist_pkg::OP_DELETE: begin
               if (pos >= held) begin
                  o.status = ilist_pkg::ST_BADPOS;
               end else begin
                  for (k = pos; k + 1 < held; k++) cells[k] = cells[k+1];
                  held--;
               end
            end
            ilist_pkg::OP_SEARCH: begin
               for (k = 0; k < held && !hit; k++) begin
                  if (cells[k] == val) begin
                     hit     = 1'b1;
                     o.found = k[ilist_pkg::FOUND_W-1:0];
                  end
               end
               if (!hit) o.status = ilist_pkg::ST_MISSING;
            end
            default: ;
         endcase
         o.held_after = held[ilist_pkg::COUNT_OUT_W-1:0];
         outcomes_due.push_back(o);
      endfunction

      // compare one accepted response beat with the oldest one owed
      function void check_outcome(logic [1:0] st, logic [ilist_pkg::FOUND_W-1:0] fp,
                                  logic [ilist_pkg::COUNT_OUT_W-1:0] cnt);
         outcome_type o;
         if (outcomes_due.size() == 0) begin
            $error("response beat with nothing owed: status %0d found %0d count %0d",
                   st, fp, cnt);
            errors++;
            return;
         end
         o = outcomes_due.pop_front();
         if (st !== o.status) begin
            $error("status: expected %0d, got %0d", o.status, st);
            errors++;
         end
         if (fp !== o.found) begin
            $error("found_position: expected %0d, got %0d", o.found, fp);
            errors++;
         end
         if (cnt !== o.held_after) begin
            $error("entry_count: expected %0d, got %0d", o.held_after, cnt);
            errors++;
         end
      endfunction
   endclass

   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_stall;
   logic [1:0]                           req_opcode;
   logic [ilist_pkg::POS_W-1:0]          req_position;
   logic signed [ilist_pkg::VALUE_W-1:0] req_value;
   logic                                 rsp_valid;
   logic                                 rsp_stall;
   logic [1:0]                           rsp_status;
   logic [ilist_pkg::FOUND_W-1:0]        rsp_found_position;
   logic [ilist_pkg::COUNT_OUT_W-1:0]    rsp_entry_count;

   list_shadow shadow;
   bit         no_idle;
   bit         hold_req;
   bit         gappy;
   int         calm_left;
   int         stuck_cycles = 0;

   indexed_list_insert_delete_search_core u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_position       (req_position),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_found_position (rsp_found_position),
      .rsp_entry_count    (rsp_entry_count)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // offer one command beat, with an optional gap first; returns once accepted
   task automatic send_cmd(input logic [1:0] op, input logic [ilist_pkg::POS_W-1:0] pos,
                           input logic signed [ilist_pkg::VALUE_W-1:0] val);
      if (calm_left == 0) begin
         calm_left = $urandom_range(10, 40);
         gappy     = 1'($urandom_range(0, 1));
      end
      calm_left--;
      if (!no_idle && gappy && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_opcode   <= op;
      req_position <= pos;
      req_value    <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      shadow.take_command(op, pos, val);
   endtask

   // pick a command from the shadow list's contents, leaning as asked
   task automatic issue_random(input lean_type lean);
      int unsigned                          roll;
      int unsigned                          ins_pct;
      int unsigned                          del_pct;
      logic [1:0]                           op;
      logic [ilist_pkg::POS_W-1:0]          pos;
      logic signed [ilist_pkg::VALUE_W-1:0] val;
      case (lean)
         LEAN_FILL: begin
            ins_pct = 80;
            del_pct = 5;
         end
         LEAN_DRAIN: begin
            ins_pct = 8;
            del_pct = 77;
         end
         default: begin
            ins_pct = 40;
            del_pct = 30;
         end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < 2)                          op = OP_UNUSED;
      else if (roll < 2 + ins_pct)           op = ilist_pkg::OP_INSERT;
      else if (roll < 2 + ins_pct + del_pct) op = ilist_pkg::OP_DELETE;
      else                                   op = ilist_pkg::OP_SEARCH;

      // mostly legal positions, some anywhere in the field
      if ($urandom_range(0, 9) == 0)
         pos = ilist_pkg::POS_W'($urandom_range(0, 255));
      else if (op == ilist_pkg::OP_DELETE && shadow.held > 0)
         pos = ilist_pkg::POS_W'($urandom_range(0, shadow.held - 1));
      else
         pos = ilist_pkg::POS_W'($urandom_range(0, shadow.held));

      // values held already, a narrow pool for duplicates, or anything
      roll = $urandom_range(0, 9);
      if (roll < 4 && shadow.held > 0)
         val = shadow.cells[$urandom_range(0, shadow.held - 1)];
      else if (roll < 7)
         val = int'($urandom_range(0, 15)) - 8;
      else
         val = $urandom;
      send_cmd(op, pos, val);
   endtask

   // response side: random stall bursts, one long hold on request
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_req = 1'b0;
         end else if (!no_idle && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         shadow.check_outcome(rsp_status, rsp_found_position, rsp_entry_count);
   end

   // watchdog: cycles with no beat on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("indexed_list_insert_delete_search_core_tb: done, errors");
         $finish;
      end
   end

   // main sequence
   initial begin
      shadow       = new();
      no_idle      = 1'b0;
      hold_req     = 1'b0;
      gappy        = 1'b0;
      calm_left    = 0;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_opcode   <= ilist_pkg::OP_INSERT;
      req_position <= '0;
      req_value    <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: empty list, extremes, duplicates, bad positions
      send_cmd(ilist_pkg::OP_SEARCH, 8'd0,   32'sd0);
      send_cmd(ilist_pkg::OP_DELETE, 8'd0,   32'sd0);
      send_cmd(ilist_pkg::OP_DELETE, 8'd255, 32'sd0);
      send_cmd(OP_UNUSED,            8'd0,   32'sd0);
      send_cmd(ilist_pkg::OP_INSERT, 8'd1,   32'sd5);
      send_cmd(ilist_pkg::OP_INSERT, 8'd0,   32'h8000_0000);
      send_cmd(ilist_pkg::OP_INSERT, 8'd1,   32'h7FFF_FFFF);
      send_cmd(ilist_pkg::OP_INSERT, 8'd0,   32'sd0);
      send_cmd(ilist_pkg::OP_INSERT, 8'd3,   -32'sd1);
      send_cmd(ilist_pkg::OP_INSERT, 8'd2,   32'sd0);
      send_cmd(ilist_pkg::OP_SEARCH, 8'd0,   32'sd0);
      send_cmd(ilist_pkg::OP_SEARCH, 8'd77,  32'h7FFF_FFFF);
      send_cmd(ilist_pkg::OP_SEARCH, 8'd0,   -32'sd1);
      send_cmd(ilist_pkg::OP_SEARCH, 8'd0,   32'sd5);
      send_cmd(ilist_pkg::OP_INSERT, 8'd255, 32'sd9);
      send_cmd(ilist_pkg::OP_INSERT, 8'd128, 32'sd9);
      send_cmd(ilist_pkg::OP_DELETE, 8'd5,   32'sd0);
      send_cmd(ilist_pkg::OP_DELETE, 8'd4,   32'sd0);
      send_cmd(ilist_pkg::OP_DELETE, 8'd0,   32'sd0);
      send_cmd(ilist_pkg::OP_DELETE, 8'd1,   32'sd0);
      send_cmd(OP_UNUSED,            8'd255, 32'h7FFF_FFFF);
      send_cmd(ilist_pkg::OP_SEARCH, 8'd0,   32'h8000_0000);

      // mixed traffic
      repeat (150) issue_random(LEAN_EVEN);

      // response side holds off while commands keep coming
      hold_req = 1'b1;
      repeat (40) issue_random(LEAN_FILL);

      // sender pauses until every response is back
      req_valid <= 1'b0;
      while (hold_req || shadow.pending() != 0) @(posedge clock);
      @(posedge clock);

      // fill to capacity, then push on the full list
      while (shadow.held < ilist_pkg::CAPACITY) issue_random(LEAN_FILL);
      repeat (12) issue_random(LEAN_FILL);

      // drain to empty, then delete on the empty list
      while (shadow.held > 0) issue_random(LEAN_DRAIN);
      repeat (8) issue_random(LEAN_DRAIN);

      repeat (150) issue_random(LEAN_EVEN);

      // closing stretch at full rate on both sides
      no_idle = 1'b1;
      repeat (150) issue_random(LEAN_EVEN);
      req_valid <= 1'b0;

      while (shadow.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (shadow.errors == 0 && shadow.pending() == 0)
         $display("indexed_list_insert_delete_search_core_tb: done, clean");
      else
         $display("indexed_list_insert_delete_search_core_tb: done, errors");
      $finish;
   end

endmodule
